>>> src/ternary_min_heap_priority_queue_core_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros for the ternary min-heap core
// Concurrent assertion wrappers, compiled out for synthesis.
// ---------------------------------------------------------------------------
`ifndef TERNARY_MIN_HEAP_PRIORITY_QUEUE_CORE_MACROS_SVH
`define TERNARY_MIN_HEAP_PRIORITY_QUEUE_CORE_MACROS_SVH
`ifndef SYNTHESIS
`define TMH_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
`define TMH_ASSERT_RST(label, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define TMH_ASSERT(label, prop, msg)
`define TMH_ASSERT_RST(label, prop, msg)
`endif
`endif

>>> src/tmh_pkg.sv
// ---------------------------------------------------------------------------
// tmh_pkg
// Shared types and constants for the ternary min-heap core.
// ---------------------------------------------------------------------------
package tmh_pkg;

	localparam int unsigned DefCapacity = 4096;
	localparam int unsigned KeyW    = 32;
	localparam int unsigned CellW   = 32;
	localparam int unsigned AspW    = 8;
	localparam int unsigned OrdW    = 32;
	localparam int unsigned HeldW   = 13;
	localparam int unsigned EntryW  = KeyW + CellW + AspW + OrdW;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_EMPTY = 2'd1;
	localparam logic [1:0] ST_FULL  = 2'd2;

	localparam logic OP_PUSH = 1'b0;
	localparam logic OP_POP  = 1'b1;

	typedef struct packed {
		logic [KeyW-1:0]  key;
		logic [CellW-1:0] cell_idx;
		logic [AspW-1:0]  asp;
		logic [OrdW-1:0]  ord;
	} entry_t;

	typedef struct packed {
		logic load_push;   // cur_q <= input entry, stamp order
		logic rd_en;       // read at rd address
		logic wr_cur;      // write cur_q at wr address
		logic wr_best;     // write best_q at wr address
		logic cur_from_rd; // cur_q <= read data
		logic take_top;    // popped regs <= read data
		logic clr_out;     // popped regs <= 0
		logic best_init;   // best_q <= read data
		logic best_cmp;    // best_q <= read data if ranks before
	} dp_cmd_t;

	typedef struct packed {
		logic cur_before_rd; // cur_q ranks before read data
	} dp_stat_t;

	function automatic logic ranks_before(entry_t a, entry_t b);
		logic signed [KeyW-1:0] ka, kb;
		ka = a.key;
		kb = b.key;
		return (ka < kb) || ((ka == kb) && (a.ord < b.ord));
	endfunction

endpackage

>>> src/ternary_min_heap_priority_queue_core.sv
// ---------------------------------------------------------------------------
// ternary_min_heap_priority_queue_core
// Ternary min-heap priority queue of raster cells, ordered by key then age.
// ---------------------------------------------------------------------------
// Usage: drive opcode and the entry fields with start high while busy is
// low; the request is taken at that edge and busy rises. A push stores the
// entry stamped with an insertion number; a pop returns the lowest key,
// earliest insertion first. Exactly one result follows each request: done
// pulses for one cycle with status, popped_* and entries_held valid.
// The receiver cannot stall; results must be captured on the done cycle.
// A push climbs from its new slot, a parent per level, until a compare
// ends the climb or the root is reached. A pop reads the top and, unless
// one entry was held, descends the hole a level per best-child move, and
// may refill it with the last entry, which then climbs the same way.
// Reads use the single read port of the heap memory; at 4096 entries a
// pop descends up to eight levels. The next request is taken on the done cycle.
// Reset clears the fill count and insertion counter; the heap memory is
// not cleared, only slots up to the fill count are ever read.
// ---------------------------------------------------------------------------
module ternary_min_heap_priority_queue_core import tmh_pkg::*; #(
	parameter int unsigned CAPACITY = DefCapacity
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	output logic                    busy,
	output logic                    done,
	input  logic                    opcode,
	input  logic signed [KeyW-1:0]  elevation_key,
	input  logic [CellW-1:0]        cell_index,
	input  logic signed [AspW-1:0]  aspect_code,
	output logic [1:0]              status,
	output logic signed [KeyW-1:0]  popped_key,
	output logic [CellW-1:0]        popped_cell,
	output logic signed [AspW-1:0]  popped_aspect,
	output logic [HeldW-1:0]        entries_held
);

	localparam int unsigned AW = $clog2(CAPACITY + 1);

	dp_cmd_t       cmd;
	dp_stat_t      stat;
	logic [AW-1:0] rd_addr, wr_addr;
	logic          rd_idx_valid, best_sel;

	tmh_ctrl #(.CAPACITY(CAPACITY), .AW(AW)) u_ctrl (
		.clk, .arst_n, .start, .opcode, .busy, .done, .status, .entries_held,
		.cmd, .rd_addr, .wr_addr, .rd_idx_valid, .best_sel, .stat
	);

	tmh_datapath #(.CAPACITY(CAPACITY), .AW(AW)) u_dp (
		.clk, .arst_n, .cmd, .rd_addr, .wr_addr,
		.in_key(elevation_key), .in_cell(cell_index), .in_asp(aspect_code),
		.rd_idx_valid, .best_sel, .stat,
		.popped_key, .popped_cell, .popped_aspect
	);

endmodule

>>> src/tmh_datapath.sv
// ---------------------------------------------------------------------------
// tmh_datapath
// Heap memory, working entry registers and entry compare.
// ---------------------------------------------------------------------------
module tmh_datapath import tmh_pkg::*; #(
	parameter int unsigned CAPACITY = DefCapacity,
	parameter int unsigned AW = $clog2(CAPACITY + 1)
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  dp_cmd_t               cmd,
	input  logic [AW-1:0]         rd_addr,
	input  logic [AW-1:0]         wr_addr,
	input  logic [KeyW-1:0]       in_key,
	input  logic [CellW-1:0]      in_cell,
	input  logic [AspW-1:0]       in_asp,
	input  logic                  rd_idx_valid,
	output logic                  best_sel,
	output dp_stat_t              stat,
	output logic [KeyW-1:0]       popped_key,
	output logic [CellW-1:0]      popped_cell,
	output logic [AspW-1:0]       popped_aspect
);

	entry_t mem [CAPACITY+1];
	entry_t rd_q, cur_q, best_q, top_q;
	logic [OrdW-1:0] ctr_q;

	always_ff @(posedge clk) begin
		if (cmd.rd_en) rd_q <= mem[rd_addr];
		if (cmd.wr_cur) mem[wr_addr] <= cur_q;
		else if (cmd.wr_best) mem[wr_addr] <= best_q;
	end

	// best_sel: read data beats current best (child scan)
	assign best_sel = rd_idx_valid && ranks_before(rd_q, best_q);
	assign stat.cur_before_rd = ranks_before(cur_q, rd_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctr_q <= '0;
		end else if (cmd.load_push) begin
			ctr_q <= ctr_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_push)
			cur_q <= '{key: in_key, cell_idx: in_cell, asp: in_asp, ord: ctr_q};
		else if (cmd.cur_from_rd) cur_q <= rd_q;
		if (cmd.best_init) best_q <= rd_q;
		else if (cmd.best_cmp && best_sel) best_q <= rd_q;
		if (cmd.take_top) top_q <= rd_q;
		else if (cmd.clr_out) top_q <= '0;
	end

	assign popped_key    = top_q.key;
	assign popped_cell   = top_q.cell_idx;
	assign popped_aspect = top_q.asp;

endmodule

>>> src/tmh_ctrl.sv
// ---------------------------------------------------------------------------
// tmh_ctrl
// Sequencer for push sift-up and pop hole descent / refill / sift-up.
// ---------------------------------------------------------------------------
`include "ternary_min_heap_priority_queue_core_macros.svh"
module tmh_ctrl import tmh_pkg::*; #(
	parameter int unsigned CAPACITY = DefCapacity,
	parameter int unsigned AW = $clog2(CAPACITY + 1)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic             opcode,
	output logic             busy,
	output logic             done,
	output logic [1:0]       status,
	output logic [HeldW-1:0] entries_held,
	output dp_cmd_t          cmd,
	output logic [AW-1:0]    rd_addr,
	output logic [AW-1:0]    wr_addr,
	output logic             rd_idx_valid,
	input  logic             best_sel,
	input  dp_stat_t         stat
);

	localparam logic [AW:0] CapW = (AW+1)'(CAPACITY);
	// floor(t/3) = (t * ceil(2^DivK / 3)) >> DivK for any t below 2^(AW+1)
	localparam int unsigned DivK = AW + 2;
	localparam logic [AW:0] Recip3 = (AW+1)'(((64'd1 << DivK) + 64'd2) / 64'd3);

	typedef enum logic [3:0] {
		S_IDLE, S_TOP, S_TOPW, S_C0, S_C1, S_C2, S_C3, S_MV,
		S_LAST, S_LASTW, S_UP, S_UPW, S_UPC, S_FIN, S_DONE
	} state_t;

	state_t        state_q;
	logic [AW:0]   fill_q;
	logic [AW:0]   hole_q;   // also sift position
	logic [AW+2:0] child_q;  // first child
	logic [AW:0]   best_q;
	logic [AW:0]   par_q;
	logic [1:0]    stat_q;
	logic          pv1_q, pv2_q; // compare slot valid, delayed with read
	logic [AW+2:0] pi1_q, pi2_q;

	// parent of slot p is (p-2)/3+1, p >= 2; divide by constant
	function automatic logic [AW:0] parent_of(logic [AW:0] p);
		logic [AW:0]     t;
		logic [2*AW+1:0] prod;
		t = p - (AW+1)'(2);
		prod = {{(AW+1){1'b0}}, t} * {{(AW+1){1'b0}}, Recip3};
		return {1'b0, prod[2*AW+1:DivK]} + (AW+1)'(1);
	endfunction

	// first child of slot p is 3p-1
	function automatic logic [AW+2:0] child3_of(logic [AW:0] p);
		return {2'b00, p} * 3 - 1;
	endfunction

	always_comb begin
		cmd = '0;
		rd_addr = '0;
		wr_addr = hole_q[AW-1:0];
		rd_idx_valid = 1'b0;
		case (state_q)
			S_TOP:  begin cmd.rd_en = 1'b1; rd_addr = AW'(1); end
			S_TOPW: cmd.take_top = 1'b1;
			S_C0:   begin cmd.rd_en = 1'b1; rd_addr = child_q[AW-1:0]; end
			S_C1:   begin
				cmd.best_init = 1'b1;
				cmd.rd_en = pv1_q;
				rd_addr = pi1_q[AW-1:0];
			end
			S_C2:   begin
				cmd.best_cmp = 1'b1;
				rd_idx_valid = pv1_q;
				cmd.rd_en = pv2_q;
				rd_addr = pi2_q[AW-1:0];
			end
			S_C3:   begin cmd.best_cmp = 1'b1; rd_idx_valid = pv2_q; end
			S_MV:   cmd.wr_best = 1'b1;
			S_LAST: begin cmd.rd_en = 1'b1; rd_addr = fill_q[AW-1:0]; end
			S_LASTW: cmd.cur_from_rd = 1'b1;
			S_UP:   begin cmd.rd_en = 1'b1; rd_addr = par_q[AW-1:0]; end
			S_UPC:  begin
				if (stat.cur_before_rd) begin
					cmd.best_init = 1'b1; // hold parent then write at hole
				end
			end
			S_UPW:  cmd.wr_best = 1'b1;
			S_FIN:  cmd.wr_cur = 1'b1;
			default: ;
		endcase
		if (state_q == S_IDLE && start && opcode == OP_PUSH && fill_q < CapW)
			cmd.load_push = 1'b1;
		if (state_q == S_IDLE && start && opcode == OP_PUSH)
			cmd.clr_out = 1'b1;
		if (state_q == S_IDLE && start && opcode == OP_POP && fill_q == '0)
			cmd.clr_out = 1'b1;
	end

	assign busy = (state_q != S_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			fill_q <= '0;
			hole_q <= '0;
			child_q <= '0;
			best_q <= '0;
			par_q <= '0;
			stat_q <= ST_OK;
			pv1_q <= 1'b0;
			pv2_q <= 1'b0;
			pi1_q <= '0;
			pi2_q <= '0;
			done <= 1'b0;
			status <= ST_OK;
			entries_held <= '0;
		end else begin
			done <= (state_q == S_DONE);
			case (state_q)
				S_IDLE: begin
					if (start) begin
						if (opcode == OP_PUSH) begin
							if (fill_q >= CapW) begin
								stat_q <= ST_FULL;
								state_q <= S_DONE;
							end else begin
								stat_q <= ST_OK;
								fill_q <= fill_q + 1'b1;
								hole_q <= fill_q + 1'b1;
								par_q <= parent_of(fill_q + 1'b1);
								if (fill_q == '0) state_q <= S_FIN;
								else state_q <= S_UP;
							end
						end else begin
							if (fill_q == '0) begin
								stat_q <= ST_EMPTY;
								state_q <= S_DONE;
							end else begin
								stat_q <= ST_OK;
								hole_q <= (AW+1)'(1);
								state_q <= S_TOP;
							end
						end
					end
				end
				S_TOP: state_q <= S_TOPW;
				S_TOPW: begin
					if (fill_q == (AW+1)'(1)) begin
						fill_q <= '0;
						state_q <= S_DONE;
					end else begin
						child_q <= (AW+3)'(2);
						state_q <= S_C0;
						pi1_q <= (AW+3)'(3);
						pi2_q <= (AW+3)'(4);
						pv1_q <= (AW+1)'(3) <= fill_q;
						pv2_q <= (AW+1)'(4) <= fill_q;
					end
				end
				S_C0: begin
					if (child_q > {2'b00, fill_q}) begin
						state_q <= S_LAST;
					end else begin
						best_q <= child_q[AW:0];
						state_q <= S_C1;
					end
				end
				S_C1: state_q <= S_C2;
				S_C2: begin
					if (best_sel) best_q <= pi1_q[AW:0];
					state_q <= S_C3;
				end
				S_C3: begin
					if (best_sel) best_q <= pi2_q[AW:0];
					state_q <= S_MV;
				end
				S_MV: begin
					hole_q <= best_q;
					child_q <= child3_of(best_q);
					pi1_q <= child3_of(best_q) + (AW+3)'(1);
					pi2_q <= child3_of(best_q) + (AW+3)'(2);
					pv1_q <= (child3_of(best_q) + (AW+3)'(1)) <= {2'b00, fill_q};
					pv2_q <= (child3_of(best_q) + (AW+3)'(2)) <= {2'b00, fill_q};
					state_q <= S_C0;
				end
				S_LAST: begin
					if (hole_q < fill_q) begin
						state_q <= S_LASTW;
					end else begin
						fill_q <= fill_q - 1'b1;
						state_q <= S_DONE;
					end
				end
				S_LASTW: begin
					fill_q <= fill_q - 1'b1;
					if (hole_q == (AW+1)'(1)) begin
						state_q <= S_FIN;
					end else begin
						par_q <= parent_of(hole_q);
						state_q <= S_UP;
					end
				end
				S_UP: state_q <= S_UPC;
				S_UPC: begin
					if (stat.cur_before_rd) state_q <= S_UPW;
					else state_q <= S_FIN;
				end
				S_UPW: begin
					hole_q <= par_q;
					if (par_q == (AW+1)'(1)) begin
						state_q <= S_FIN;
					end else begin
						par_q <= parent_of(par_q);
						state_q <= S_UP;
					end
				end
				S_FIN: state_q <= S_DONE;
				S_DONE: begin
					status <= stat_q;
					entries_held <= HeldW'(fill_q);
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	`TMH_ASSERT(a_fill_cap, fill_q <= CapW, "fill count above capacity")
	`TMH_ASSERT(a_done_idle, done |-> state_q == S_IDLE, "done outside idle")
	`TMH_ASSERT(a_push_stamp, cmd.load_push |=> fill_q == $past(fill_q) + 1'b1, "fill not grown")
	`TMH_ASSERT_RST(a_rst_idle, !arst_n |-> !done, "done during reset")

endmodule
